### hw/rtl/bbge_pkg.sv
// Package for the back-edge graph encoder: widths, capacity, controller states.
// No dependencies.
package bbge_pkg;
   localparam int MaxBits = 1024;
   localparam int NodeW = $clog2(MaxBits + 1);
   localparam int AddrW = $clog2(MaxBits);
   localparam int RandW = 31;

   typedef enum logic [2:0] {
      ST_IDLE, ST_DIV, ST_READ_STACK, ST_READ_HIST, ST_UPDATE, ST_OUT0, ST_OUT1
   } state_type;

   typedef struct packed {
      logic load;
      logic clear;
      logic div_step;
      logic rd_stack;
      logic rd_hist;
      logic update;
      logic do_back;
   } cmd_type;

   typedef struct packed {
      logic started;
      logic full;
      logic sel_empty;
      logic div_done;
   } stat_type;
endpackage

### hw/rtl/bbge_if.sv
// Valid/ready channel interfaces for the encoder's request and response.
// No dependencies.
interface bbge_req_if;
   logic valid;
   logic ready;
   logic message_bit;
   logic [30:0] random_word;
   logic message_start;
   modport source (output valid, message_bit, random_word, message_start, input ready);
   modport sink (input valid, message_bit, random_word, message_start, output ready);
endinterface

interface bbge_rsp_if;
   logic valid;
   logic ready;
   logic [10:0] edge_source;
   logic [10:0] edge_target;
   logic edge_kind;
   logic run_last;
   logic overflow;
   modport source (output valid, edge_source, edge_target, edge_kind, run_last, overflow,
      input ready);
   modport sink (input valid, edge_source, edge_target, edge_kind, run_last, overflow,
      output ready);
endinterface

### hw/rtl/bbge_datapath.sv
// Datapath: node counter, stack depths, stack/history memories, serial modulo.
// Depends on bbge_pkg.
module bbge_datapath (
   input  logic clock,
   input  logic reset,
   input  bbge_pkg::cmd_type cmd,
   input  logic in_bit,
   input  logic [30:0] in_rand,
   output bbge_pkg::stat_type stat,
   output logic [10:0] idx_out,
   output logic [10:0] tgt_out
);
   import bbge_pkg::*;

   logic started_ff, started_in;
   logic [NodeW-1:0] cnt_ff, cnt_in, ed_ff, ed_in, od_ff, od_in;
   logic bit_ff;
   logic [RandW-1:0] quo_ff, quo_in;
   logic [NodeW-1:0] rem_ff, rem_in;
   logic [4:0] step_ff, step_in;
   logic [AddrW-1:0] even_mem [MaxBits];
   logic [AddrW-1:0] odd_mem [MaxBits];
   logic [NodeW-1:0] hist_mem [MaxBits];
   logic [AddrW-1:0] tgt_ff;
   logic [NodeW-1:0] rec_ff;
   logic even, pick_even;
   logic [NodeW-1:0] sel_d, oth_d, ndep, k1;
   logic [NodeW:0] trial;

   assign even = ~cnt_ff[0];
   assign pick_even = (even & bit_ff) | (~even & ~bit_ff);
   assign sel_d = pick_even ? ed_ff : od_ff;
   assign oth_d = pick_even ? od_ff : ed_ff;
   assign trial = {rem_ff, quo_ff[RandW-1]} - {1'b0, sel_d};
   assign k1 = rem_ff + NodeW'(1);

   assign stat.started = started_ff;
   assign stat.full = (cnt_ff == NodeW'(MaxBits));
   assign stat.sel_empty = (sel_d == '0);
   assign stat.div_done = (step_ff == 5'(RandW - 1));
   assign idx_out = cnt_ff;
   assign tgt_out = {1'b0, tgt_ff};

   always_comb begin
      started_in = started_ff;
      cnt_in = cnt_ff;
      ed_in = ed_ff;
      od_in = od_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      step_in = step_ff;
      ndep = '0;
      if (cmd.clear) begin
         started_in = 1'b0;
         cnt_in = '0;
         ed_in = '0;
         od_in = '0;
      end
      if (cmd.load) begin
         started_in = 1'b1;
         quo_in = in_rand;
         rem_in = '0;
         step_in = '0;
      end
      if (cmd.div_step) begin
         quo_in = {quo_ff[RandW-2:0], ~trial[NodeW]};
         rem_in = trial[NodeW] ? {rem_ff[NodeW-2:0], quo_ff[RandW-1]} : trial[NodeW-1:0];
         step_in = step_ff + 5'd1;
      end
      if (cmd.update) begin
         cnt_in = cnt_ff + NodeW'(1);
         if (cmd.do_back) begin
            if (pick_even) begin
               if (ed_ff > k1) ed_in = k1;
               if (od_ff > rec_ff) od_in = rec_ff;
            end else begin
               if (od_ff > k1) od_in = k1;
               if (ed_ff > rec_ff) ed_in = rec_ff;
            end
         end
         ndep = even ? od_in : ed_in;
         if (ndep < NodeW'(MaxBits)) begin
            if (even) od_in = ndep + NodeW'(1);
            else ed_in = ndep + NodeW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff <= 1'b0;
         cnt_ff <= '0;
         ed_ff <= '0;
         od_ff <= '0;
         step_ff <= '0;
      end else begin
         started_ff <= started_in;
         cnt_ff <= cnt_in;
         ed_ff <= ed_in;
         od_ff <= od_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (cmd.load) bit_ff <= in_bit;
      if (cmd.rd_stack)
         tgt_ff <= pick_even ? even_mem[rem_ff[AddrW-1:0]] : odd_mem[rem_ff[AddrW-1:0]];
      if (cmd.rd_hist) rec_ff <= hist_mem[tgt_ff];
      if (cmd.update) begin
         hist_mem[cnt_ff[AddrW-1:0]] <= even ? ed_in : od_in;
         if (ndep < NodeW'(MaxBits)) begin
            if (even) odd_mem[ndep[AddrW-1:0]] <= cnt_ff[AddrW-1:0];
            else even_mem[ndep[AddrW-1:0]] <= cnt_ff[AddrW-1:0];
         end
      end
   end
endmodule

### hw/rtl/bbge_ctrl.sv
// Controller state machine: sequences modulo, memory reads, update, results.
// Depends on bbge_pkg.
module bbge_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   input  logic req_bit,
   input  logic req_start,
   output logic req_ready,
   input  logic out_ready,
   output logic out_valid,
   output logic out_sel1,
   output logic out_kind,
   output logic out_last,
   output logic out_ovf,
   input  bbge_pkg::stat_type stat,
   output bbge_pkg::cmd_type cmd
);
   import bbge_pkg::*;

   state_type state_ff, state_in;
   logic back_ff, back_in, ovf_ff, ovf_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         back_ff <= 1'b0;
         ovf_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         back_ff <= back_in;
         ovf_ff <= ovf_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      back_in = back_ff;
      ovf_in = ovf_ff;
      cmd = '0;
      req_ready = 1'b0;
      out_valid = 1'b0;
      out_sel1 = 1'b0;
      out_kind = 1'b0;
      out_last = 1'b0;
      out_ovf = 1'b0;
      cmd.do_back = back_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.clear = req_start;
               if ((stat.started && !req_start) || req_bit) begin
                  cmd.load = 1'b1;
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (stat.full) begin
               ovf_in = 1'b1;
               back_in = 1'b0;
               state_in = ST_OUT0;
            end else if (stat.sel_empty) begin
               ovf_in = 1'b0;
               back_in = 1'b0;
               state_in = ST_UPDATE;
            end else begin
               ovf_in = 1'b0;
               back_in = 1'b1;
               cmd.div_step = 1'b1;
               if (stat.div_done) state_in = ST_READ_STACK;
            end
         end
         ST_READ_STACK: begin
            cmd.rd_stack = 1'b1;
            state_in = ST_READ_HIST;
         end
         ST_READ_HIST: begin
            cmd.rd_hist = 1'b1;
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            state_in = ST_OUT0;
         end
         ST_OUT0: begin
            out_valid = 1'b1;
            out_ovf = ovf_ff;
            out_last = ovf_ff | ~back_ff;
            if (out_ready) begin
               if (ovf_ff) state_in = ST_IDLE;
               else if (back_ff) state_in = ST_OUT1;
               else begin
                  cmd.update = 1'b1;
                  state_in = ST_IDLE;
               end
            end
         end
         ST_OUT1: begin
            out_valid = 1'b1;
            out_sel1 = 1'b1;
            out_kind = 1'b1;
            out_last = 1'b1;
            if (out_ready) begin
               cmd.update = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule

### hw/rtl/bits_to_backedge_graph_encoder.sv
// Back-edge graph encoder: each accepted bit after any leading zeros becomes a node
// with a path edge and, when the chosen stack is non-empty, a back edge. Leading
// zeros are dropped. A back edge comes from the 31-step serial modulo followed
// by stack and history memory reads. A new bit is accepted only after the result
// side has taken every edge of the last one. Up to 1024 nodes; beyond that each
// bit reports overflow.
module bits_to_backedge_graph_encoder (
   input logic clock,
   input logic reset,
   bbge_req_if.sink req,
   bbge_rsp_if.source rsp
);
   import bbge_pkg::*;

   cmd_type cmd;
   stat_type stat;
   logic sel1, kind, last, ovf, vld;
   logic [10:0] idx, tgt;

   bbge_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req.valid), .req_bit(req.message_bit), .req_start(req.message_start),
      .req_ready(req.ready), .out_ready(rsp.ready), .out_valid(vld),
      .out_sel1(sel1), .out_kind(kind), .out_last(last), .out_ovf(ovf),
      .stat(stat), .cmd(cmd)
   );

   bbge_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd),
      .in_bit(req.message_bit), .in_rand(req.random_word),
      .stat(stat), .idx_out(idx), .tgt_out(tgt)
   );

   assign rsp.valid = vld;
   assign rsp.edge_source = ovf ? 11'd0 : idx;
   assign rsp.edge_target = ovf ? 11'd0 : (sel1 ? tgt : idx + 11'd1);
   assign rsp.edge_kind = kind;
   assign rsp.run_last = last;
   assign rsp.overflow = ovf;
endmodule

### test/tb_bits_to_backedge_graph_encoder.sv
// Testbench for the back-edge graph encoder: random and directed bit streams,
// edges checked against an in-bench predictor. Depends on bbge_pkg and bbge_if.
`timescale 1ns / 100ps

module tb_bits_to_backedge_graph_encoder;
   import bbge_pkg::*;

   typedef struct packed {
      logic       message_bit;
      logic [30:0] random_word;
      logic       message_start;
   } bit_item_type;

   typedef struct packed {
      logic [10:0] edge_source;
      logic [10:0] edge_target;
      logic        edge_kind;
      logic        run_last;
      logic        overflow;
   } edge_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   bbge_req_if req ();
   bbge_rsp_if rsp ();

   bits_to_backedge_graph_encoder dut (.clock(clock), .reset(reset), .req(req), .rsp(rsp));

   always #10 clock = ~clock;

   bit_item_type  pending_bits[$];
   edge_item_type expected_edges[$];
   int         errors = 0;
   int         cycle_count = 0;
   bit         hold_rsp = 1'b0;

   // encoder state copy
   bit          enc_started;
   int unsigned enc_nodes;
   int unsigned ev_nodes[MaxBits];
   int unsigned od_nodes[MaxBits];
   int unsigned even_depth, odd_depth;
   int unsigned depth_hist[MaxBits];

   function automatic void push_edge(int unsigned src, int unsigned dst, int unsigned kind,
                                     int unsigned last, int unsigned ovf);
      edge_item_type e;
      e.edge_source = src[10:0];
      e.edge_target = dst[10:0];
      e.edge_kind   = kind[0];
      e.run_last    = last[0];
      e.overflow    = ovf[0];
      expected_edges.push_back(e);
   endfunction

   function automatic void encode_bit(bit_item_type it);
      int unsigned idx, k, tgt, rec;
      bit even, pick_even;
      int unsigned sdep;
      if (it.message_start) begin
         enc_started = 0; enc_nodes = 0; even_depth = 0; odd_depth = 0;
      end
      if (!enc_started) begin
         if (!it.message_bit) return;
         enc_started = 1;
      end
      if (enc_nodes >= MaxBits) begin
         push_edge(0, 0, 0, 1, 1);
         return;
      end
      idx = enc_nodes;
      even = (idx % 2) == 0;
      pick_even = even ? it.message_bit : !it.message_bit;
      sdep = pick_even ? even_depth : odd_depth;
      if (sdep != 0) begin
         k = it.random_word % sdep;
         tgt = pick_even ? ev_nodes[k] : od_nodes[k];
         rec = depth_hist[tgt];
         push_edge(idx, idx + 1, 0, 0, 0);
         push_edge(idx, tgt, 1, 1, 0);
         if (pick_even) begin
            if (even_depth > k + 1) even_depth = k + 1;
            if (odd_depth > rec) odd_depth = rec;
         end else begin
            if (odd_depth > k + 1) odd_depth = k + 1;
            if (even_depth > rec) even_depth = rec;
         end
      end else
         push_edge(idx, idx + 1, 0, 1, 0);
      enc_nodes = idx + 1;
      if (even) begin
         if (odd_depth < MaxBits) od_nodes[odd_depth++] = idx;
         depth_hist[idx] = even_depth;
      end else begin
         if (even_depth < MaxBits) ev_nodes[even_depth++] = idx;
         depth_hist[idx] = odd_depth;
      end
   endfunction

   function automatic void add_bit(int unsigned b, int unsigned r, int unsigned s);
      bit_item_type it;
      it.message_bit = b[0];
      it.random_word = r[30:0];
      it.message_start = s[0];
      pending_bits.push_back(it);
   endfunction

   // driver
   int req_wait = 0;
   always @(posedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
      end else if (req.valid && req.ready) begin
         encode_bit(pending_bits.pop_front());
         req_wait = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 19);
         if (req_wait == 0 && pending_bits.size() > 0) begin
            req.valid <= 1'b1;
            {req.message_bit, req.random_word, req.message_start} <= pending_bits[0];
         end else
            req.valid <= 1'b0;
      end else if (!req.valid) begin
         if (req_wait > 0)
            req_wait--;
         else if (pending_bits.size() > 0) begin
            req.valid <= 1'b1;
            {req.message_bit, req.random_word, req.message_start} <= pending_bits[0];
         end
      end
   end

   // monitor
   int rsp_wait = 0;
   always @(posedge clock) begin
      edge_item_type got, exp_e;
      cycle_count++;
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            got = {rsp.edge_source, rsp.edge_target, rsp.edge_kind, rsp.run_last,
                   rsp.overflow};
            if (expected_edges.size() == 0) begin
               $display("%0t: unexpected edge %h", $time, got);
               errors++;
            end else begin
               exp_e = expected_edges.pop_front();
               if (got !== exp_e) begin
                  $display("%0t: edge mismatch expected %h actual %h", $time, exp_e, got);
                  errors++;
               end
            end
            rsp_wait = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 19);
         end
         if (hold_rsp)
            rsp.ready <= 1'b0;
         else if (rsp_wait > 0) begin
            rsp_wait--;
            rsp.ready <= 1'b0;
         end else
            rsp.ready <= 1'b1;
      end
   end

   // long receiver hold-off, counted here
   initial begin
      int n;
      n = 0;
      wait (!reset);
      repeat (3000) @(posedge clock);
      hold_rsp = 1'b1;
      while (n < 600) begin
         @(posedge clock);
         n++;
      end
      hold_rsp = 1'b0;
   end

   initial begin
      int i, len;
      req.valid = 1'b0;
      req.message_bit = 1'b0;
      req.random_word = '0;
      req.message_start = 1'b0;
      rsp.ready = 1'b0;
      enc_started = 0; enc_nodes = 0; even_depth = 0; odd_depth = 0;
      // bits before any start, leading zeros, extremes of the random word
      add_bit(0, 31'h7fffffff, 0);
      add_bit(1, 31'h7fffffff, 0);
      add_bit(1, 0, 0);
      add_bit(0, 31'h7fffffff, 0);
      add_bit(0, 31'h55555555, 0);
      add_bit(1, 31'h2aaaaaaa, 0);
      add_bit(0, 31'h0, 1);
      add_bit(0, 31'h1, 0);
      add_bit(1, 31'h3, 0);
      add_bit(1, 31'h7ffffffe, 0);
      add_bit(0, 31'h12345, 0);
      add_bit(1, 31'h7fffffff, 1);
      add_bit(0, 31'h0, 0);
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      wait (pending_bits.size() == 0);
      // sender pause until all edges are back
      wait (expected_edges.size() == 0);
      // one full message past capacity for overflow, sparse back edges
      add_bit(1, $urandom, 1);
      for (i = 0; i < MaxBits + 3; i++)
         add_bit($urandom_range(0, 1), $urandom, 0);
      // random messages, mostly short
      while (pending_bits.size() < 1600) begin
         len = $urandom_range(1, 60);
         add_bit($urandom_range(0, 1), $urandom, 1);
         for (i = 0; i < len; i++)
            add_bit($urandom_range(0, 7) != 0 ? $urandom_range(0, 1) : 0,
                    $urandom_range(0, 1) ? $urandom : $urandom_range(0, 5), 0);
      end
      wait (pending_bits.size() == 0 && expected_edges.size() == 0);
      repeat (60) @(posedge clock);
      if (errors == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   always @(posedge clock) begin
      if (cycle_count > 900000) begin
         $display("FAILURE");
         $finish;
      end
   end
endmodule

### sim.f
hw/rtl/bbge_pkg.sv
hw/rtl/bbge_if.sv
hw/rtl/bbge_datapath.sv
hw/rtl/bbge_ctrl.sv
hw/rtl/bits_to_backedge_graph_encoder.sv
test/tb_bits_to_backedge_graph_encoder.sv
